[rtl/soc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

  // obstacle table entry
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [9:0]         radius;
  } entry_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DET_XX  = 7'b0000010,
    ST_DET_YY  = 7'b0000100,
    ST_DET_SUM = 7'b0001000,
    ST_FETCH   = 7'b0010000,
    ST_CALC    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  // per-obstacle sequence, each multiply step named after the multiply issued in that cycle
  typedef enum logic [3:0] {
    STEP_LOAD_OFS   = 4'd0,
    STEP_MUL_DXOX   = 4'd1,
    STEP_MUL_DYOY   = 4'd2,
    STEP_MUL_DXOY   = 4'd3,
    STEP_MUL_DYOX   = 4'd4,
    STEP_MUL_RR     = 4'd5,
    STEP_MUL_SQ     = 4'd6,
    STEP_MUL_RHS_LO = 4'd7,
    STEP_MUL_RHS_HI = 4'd8,
    STEP_COMPARE    = 4'd9
  } step_e;

  localparam int unsigned MulW  = 28;
  localparam int unsigned ProdW = 2 * MulW;

endpackage

`default_nettype wire

[rtl/segment_obstacle_collision.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    op_i, entry_index_i, obstacle_*_i,
//                                                start_x_i, start_y_i, end_x_i, end_y_i
// out      output     out_valid_o / out_ready_i  collision_o
//
// a load is written while the block stays ready. a query first computes the segment
// length, then per table entry skips it if hidden, rejects it early on the projection or
// cross-product test, or tests it fully, then hands the flag to the output register.
// all of it runs through one 28x28 signed multiplier with a registered product.
// reset clears the visibility bits at once; centre and radius storage is not cleared.
// a query stops walking at the first hit; a full output register holds the block in
// its handoff cycle until the flag is taken.

module segment_obstacle_collision #(
  parameter int unsigned NUM_OBSTACLES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [4:0]         entry_index_i,
  input  wire logic signed [15:0] obstacle_x_i,
  input  wire logic signed [15:0] obstacle_y_i,
  input  wire logic [9:0]         obstacle_radius_i,
  input  wire logic [1:0]         obstacle_visibility_i,
  input  wire logic signed [15:0] start_x_i,
  input  wire logic signed [15:0] start_y_i,
  input  wire logic signed [15:0] end_x_i,
  input  wire logic signed [15:0] end_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    collision_o
);

  localparam int unsigned IdxW = (NUM_OBSTACLES > 1) ? $clog2(NUM_OBSTACLES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_OBSTACLES - 1);

  soc_pkg::state_e state_q, state_d;
  soc_pkg::step_e  step_q, step_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q, hit_d;
  logic            out_valid_q, out_valid_d;
  logic            collision_q, collision_d;

  logic [NUM_OBSTACLES-1:0] vis_q;
  soc_pkg::entry_t          obs_mem_q [NUM_OBSTACLES];
  soc_pkg::entry_t          rd_q;

  logic signed [15:0] sx_q, sy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0]        det_q;
  logic signed [16:0] ox_q, oy_q;
  logic signed [34:0] acc_q;
  logic [26:0]        ac_q;
  logic [19:0]        rr_q;
  logic [53:0]        sq_q;
  logic [36:0]        rhs_q;

  logic signed [soc_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [soc_pkg::ProdW-1:0] mul_p, prod_q;

  logic               query_acc, load_we;
  logic [IdxW-1:0]    wr_idx;
  logic [33:0]        det_sum;
  logic signed [34:0] lam, xprod;
  logic [34:0]        ac_full;
  logic               lam_ok;
  logic [54:0]        rhs_full;
  logic               hit_now;

  assign in_ready_o  = (state_q == soc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign collision_o = collision_q;

  assign query_acc = in_valid_i && in_ready_o && op_i;
  assign load_we   = in_valid_i && in_ready_o && !op_i
                     && (9'(entry_index_i) < 9'(NUM_OBSTACLES));
  assign wr_idx    = IdxW'(entry_index_i);

  assign det_sum  = det_q + prod_q[33:0];
  assign lam      = acc_q + prod_q[34:0];
  assign xprod    = acc_q - prod_q[34:0];
  assign ac_full  = xprod[34] ? 35'(-xprod) : 35'(xprod);
  // projection must land on the segment: 0 <= lam <= det
  assign lam_ok   = !lam[34] && (lam[33:0] <= det_q);
  assign rhs_full = 55'(rhs_q) + {prod_q[37:0], 17'b0};
  assign hit_now  = (55'(sq_q) <= rhs_full);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      soc_pkg::ST_DET_XX: begin
        mul_a = {{11{dx_q[16]}}, dx_q};
        mul_b = {{11{dx_q[16]}}, dx_q};
      end
      soc_pkg::ST_DET_YY: begin
        mul_a = {{11{dy_q[16]}}, dy_q};
        mul_b = {{11{dy_q[16]}}, dy_q};
      end
      soc_pkg::ST_CALC: begin
        case (step_q)
          soc_pkg::STEP_MUL_DXOX: begin
            mul_a = {{11{dx_q[16]}}, dx_q};
            mul_b = {{11{ox_q[16]}}, ox_q};
          end
          soc_pkg::STEP_MUL_DYOY: begin
            mul_a = {{11{dy_q[16]}}, dy_q};
            mul_b = {{11{oy_q[16]}}, oy_q};
          end
          soc_pkg::STEP_MUL_DXOY: begin
            mul_a = {{11{dx_q[16]}}, dx_q};
            mul_b = {{11{oy_q[16]}}, oy_q};
          end
          soc_pkg::STEP_MUL_DYOX: begin
            mul_a = {{11{dy_q[16]}}, dy_q};
            mul_b = {{11{ox_q[16]}}, ox_q};
          end
          soc_pkg::STEP_MUL_RR: begin
            mul_a = {18'b0, rd_q.radius};
            mul_b = {18'b0, rd_q.radius};
          end
          soc_pkg::STEP_MUL_SQ: begin
            mul_a = {1'b0, ac_q};
            mul_b = {1'b0, ac_q};
          end
          soc_pkg::STEP_MUL_RHS_LO: begin
            mul_a = {8'b0, rr_q};
            mul_b = {11'b0, det_q[16:0]};
          end
          soc_pkg::STEP_MUL_RHS_HI: begin
            mul_a = {8'b0, rr_q};
            mul_b = {11'b0, det_q[33:17]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    collision_d = collision_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      soc_pkg::ST_IDLE: begin
        if (query_acc) begin
          state_d = soc_pkg::ST_DET_XX;
        end
      end
      soc_pkg::ST_DET_XX: begin
        state_d = soc_pkg::ST_DET_YY;
      end
      soc_pkg::ST_DET_YY: begin
        state_d = soc_pkg::ST_DET_SUM;
      end
      soc_pkg::ST_DET_SUM: begin
        // zero-length segment never collides
        if (det_sum == '0) begin
          hit_d   = 1'b0;
          state_d = soc_pkg::ST_DONE;
        end else begin
          idx_d   = '0;
          state_d = soc_pkg::ST_FETCH;
        end
      end
      soc_pkg::ST_FETCH: begin
        if (vis_q[idx_q]) begin
          step_d  = soc_pkg::STEP_LOAD_OFS;
          state_d = soc_pkg::ST_CALC;
        end else if (idx_q == LastIdx) begin
          hit_d   = 1'b0;
          state_d = soc_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      soc_pkg::ST_CALC: begin
        step_d = soc_pkg::step_e'(step_q + 4'd1);
        if ((step_q == soc_pkg::STEP_COMPARE && hit_now)) begin
          hit_d   = 1'b1;
          state_d = soc_pkg::ST_DONE;
        end else if ((step_q == soc_pkg::STEP_MUL_DXOY && !lam_ok)
                     || (step_q == soc_pkg::STEP_MUL_RR && ac_full[34:27] != '0)
                     || step_q == soc_pkg::STEP_COMPARE) begin
          // this obstacle is missed: move on
          if (idx_q == LastIdx) begin
            hit_d   = 1'b0;
            state_d = soc_pkg::ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = soc_pkg::ST_FETCH;
          end
        end
      end
      soc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          collision_d = hit_q;
          state_d     = soc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = soc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= soc_pkg::ST_IDLE;
      step_q      <= soc_pkg::STEP_LOAD_OFS;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      vis_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (load_we) begin
        vis_q[wr_idx] <= |obstacle_visibility_i;
      end
    end
  end

  // obstacle storage
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      obs_mem_q[wr_idx] <= '{cx: obstacle_x_i, cy: obstacle_y_i,
                             radius: obstacle_radius_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= obs_mem_q[idx_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q      <= mul_p;
    hit_q       <= hit_d;
    collision_q <= collision_d;
    if (query_acc) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      dx_q <= {end_x_i[15], end_x_i} - {start_x_i[15], start_x_i};
      dy_q <= {end_y_i[15], end_y_i} - {start_y_i[15], start_y_i};
    end
    if (state_q == soc_pkg::ST_DET_YY) begin
      det_q <= prod_q[33:0];
    end
    if (state_q == soc_pkg::ST_DET_SUM) begin
      det_q <= det_sum;
    end
    if (state_q == soc_pkg::ST_CALC) begin
      case (step_q)
        soc_pkg::STEP_LOAD_OFS: begin
          ox_q <= {rd_q.cx[15], rd_q.cx} - {sx_q[15], sx_q};
          oy_q <= {rd_q.cy[15], rd_q.cy} - {sy_q[15], sy_q};
        end
        soc_pkg::STEP_MUL_DYOY:   acc_q <= prod_q[34:0];
        soc_pkg::STEP_MUL_DYOX:   acc_q <= prod_q[34:0];
        soc_pkg::STEP_MUL_RR:     ac_q  <= ac_full[26:0];
        soc_pkg::STEP_MUL_SQ:     rr_q  <= prod_q[19:0];
        soc_pkg::STEP_MUL_RHS_LO: sq_q  <= prod_q[53:0];
        soc_pkg::STEP_MUL_RHS_HI: rhs_q <= prod_q[36:0];
        default: begin
        end
      endcase
    end
  end

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i) |=> (state_q == soc_pkg::ST_DET_XX))
    else $error("accepted query did not start the length computation");

  a_load_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !op_i) |=> in_ready_o)
    else $error("load item left the block busy");

  a_done_hands_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == soc_pkg::ST_DONE && (!out_valid_o || out_ready_i))
      |=> (out_valid_o && in_ready_o))
    else $error("finished query flag not moved to the output register");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == soc_pkg::ST_FETCH || state_q == soc_pkg::ST_CALC) |-> (idx_q <= LastIdx))
    else $error("table walk index beyond last entry");

endmodule

`default_nettype wire

[bench/segment_obstacle_collision_tb.sv]
`timescale 1ns / 1ps

module segment_obstacle_collision_tb;

  localparam int NUM_OBSTACLES    = 32;
  localparam int ITEM_TARGET      = 950;
  localparam int GAP_MAX          = 14;
  localparam int SINK_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES     = 5 + 11 * NUM_OBSTACLES + 40;
  localparam int CYCLE_LIMIT      = 1_500_000;
  localparam int PRINT_LIMIT      = 100;

  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    VIS_HIDDEN    = 2'd0,
    VIS_SHOWN     = 2'd1,
    VIS_SHOWN_ALT = 2'd2,
    VIS_RESERVED  = 2'd3
  } vis_e;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    op_e                op;
    logic [4:0]         idx;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [9:0]         rad;
    logic [1:0]         vis;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } seg_item_t;

  typedef struct {
    bit                 flag;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } query_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         r;
  } disc_t;

  logic               clk_i;
  logic               rst_ni                = 1'b0;
  logic               in_valid_i            = 1'b0;
  logic               in_ready_o;
  logic               op_i                  = 1'b0;
  logic [4:0]         entry_index_i         = '0;
  logic signed [15:0] obstacle_x_i          = '0;
  logic signed [15:0] obstacle_y_i          = '0;
  logic [9:0]         obstacle_radius_i     = '0;
  logic [1:0]         obstacle_visibility_i = '0;
  logic signed [15:0] start_x_i             = '0;
  logic signed [15:0] start_y_i             = '0;
  logic signed [15:0] end_x_i               = '0;
  logic signed [15:0] end_y_i               = '0;
  logic               out_valid_o;
  logic               out_ready_i           = 1'b0;
  logic               collision_o;

  segment_obstacle_collision #(
    .NUM_OBSTACLES(NUM_OBSTACLES)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .op_i                 (op_i),
    .entry_index_i        (entry_index_i),
    .obstacle_x_i         (obstacle_x_i),
    .obstacle_y_i         (obstacle_y_i),
    .obstacle_radius_i    (obstacle_radius_i),
    .obstacle_visibility_i(obstacle_visibility_i),
    .start_x_i            (start_x_i),
    .start_y_i            (start_y_i),
    .end_x_i              (end_x_i),
    .end_y_i              (end_y_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .collision_o          (collision_o)
  );

  // shadow of the obstacle table
  logic signed [15:0] centre_x_tbl [NUM_OBSTACLES];
  logic signed [15:0] centre_y_tbl [NUM_OBSTACLES];
  logic [9:0]         radius_tbl   [NUM_OBSTACLES];
  logic [1:0]         vis_tbl      [NUM_OBSTACLES] = '{default: VIS_HIDDEN};

  query_t expected_hits[$];
  int     mismatch_count = 0;
  int     items_sent     = 0;
  int     cycle_count    = 0;
  bit     src_burst      = 1'b0;
  bit     hold_go        = 1'b0;
  logic   sink_hold      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit predict_collision(logic signed [15:0] sx, logic signed [15:0] sy,
                                           logic signed [15:0] ex, logic signed [15:0] ey);
    wide_t dx, dy, det, ox, oy, dot, xprod, rad;
    bit    hit;
    int    i;
    hit = 1'b0;
    dx  = wide_t'(ex) - wide_t'(sx);
    dy  = wide_t'(ey) - wide_t'(sy);
    det = dx * dx + dy * dy;
    // zero-length segment never collides
    if (det == 0) return 1'b0;
    for (i = 0; i < NUM_OBSTACLES; i++) begin
      if (vis_tbl[i] != VIS_HIDDEN) begin
        ox    = wide_t'(centre_x_tbl[i]) - wide_t'(sx);
        oy    = wide_t'(centre_y_tbl[i]) - wide_t'(sy);
        dot   = dx * ox + dy * oy;
        xprod = dx * oy - dy * ox;
        rad   = radius_tbl[i];
        if (dot >= 0 && dot <= det && xprod * xprod <= rad * rad * det) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    return 16'($urandom);
  endfunction

  // random point around base, saturated to the coordinate range
  function automatic logic signed [15:0] coord_near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic int gap_cycles(bit burst);
    return burst ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  // unused fields of the other operation carry random junk
  function automatic seg_item_t load_item(logic [4:0] idx, logic signed [15:0] x,
                                          logic signed [15:0] y, logic [9:0] r,
                                          logic [1:0] vis);
    seg_item_t it;
    it.op  = OP_LOAD;
    it.idx = idx;
    it.ox  = x;
    it.oy  = y;
    it.rad = r;
    it.vis = vis;
    it.sx  = rand_coord();
    it.sy  = rand_coord();
    it.ex  = rand_coord();
    it.ey  = rand_coord();
    return it;
  endfunction

  function automatic seg_item_t query_item(logic signed [15:0] sx, logic signed [15:0] sy,
                                           logic signed [15:0] ex, logic signed [15:0] ey);
    seg_item_t it;
    it.op  = OP_QUERY;
    it.idx = 5'($urandom);
    it.ox  = rand_coord();
    it.oy  = rand_coord();
    it.rad = 10'($urandom);
    it.vis = 2'($urandom);
    it.sx  = sx;
    it.sy  = sy;
    it.ex  = ex;
    it.ey  = ey;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_collision(logic got);
    query_t q;
    if (expected_hits.size() == 0) begin
      report_mismatch($sformatf("collision result %b with no query pending", got));
    end else begin
      q = expected_hits.pop_front();
      if (got !== q.flag) begin
        report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) collision %b, predicted %b",
                                  q.sx, q.sy, q.ex, q.ey, got, q.flag));
      end
    end
  endtask

  task automatic send_item(seg_item_t it);
    int     gap;
    query_t q;
    gap = gap_cycles(src_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    op_i                  <= it.op;
    entry_index_i         <= it.idx;
    obstacle_x_i          <= it.ox;
    obstacle_y_i          <= it.oy;
    obstacle_radius_i     <= it.rad;
    obstacle_visibility_i <= it.vis;
    start_x_i             <= it.sx;
    start_y_i             <= it.sy;
    end_x_i               <= it.ex;
    end_y_i               <= it.ey;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    if (it.op == OP_LOAD) begin
      centre_x_tbl[it.idx] = it.ox;
      centre_y_tbl[it.idx] = it.oy;
      radius_tbl[it.idx]   = it.rad;
      vis_tbl[it.idx]      = it.vis;
    end else begin
      q.flag = predict_collision(it.sx, it.sy, it.ex, it.ey);
      q.sx   = it.sx;
      q.sy   = it.sy;
      q.ex   = it.ex;
      q.ey   = it.ey;
      expected_hits.push_back(q);
    end
  endtask

  // result side: random stall per item, runs of no stall, long hold on request
  initial begin : result_sink
    int stall_left;
    bit no_stall;
    stall_left = 0;
    no_stall   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        check_collision(collision_o);
        if ($urandom_range(0, 31) == 0) no_stall = !no_stall;
        stall_left = gap_cycles(no_stall);
      end else if (stall_left > 0 && out_valid_o === 1'b1) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0) && !sink_hold;
    end
  end

  initial begin : sink_hold_timer
    forever begin
      wait (hold_go);
      hold_go = 1'b0;
      sink_hold <= 1'b1;
      repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_directed();
    // nothing loaded yet, every entry hidden
    send_item(query_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    // zero radius lying on the segment
    send_item(load_item(5'd0, 16'sd0, 16'sd0, 10'd0, VIS_SHOWN));
    send_item(query_item(-16'sd10, 16'sd0, 16'sd10, 16'sd0));
    send_item(query_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // hidden entry is skipped
    send_item(load_item(5'd0, 16'sd100, 16'sd0, 10'd10, VIS_HIDDEN));
    send_item(query_item(16'sd0, 16'sd0, 16'sd200, 16'sd0));
    // visibility three counts as visible; tangent touches exactly
    send_item(load_item(5'd31, 16'sd100, 16'sd10, 10'd10, VIS_RESERVED));
    send_item(query_item(16'sd0, 16'sd0, 16'sd200, 16'sd0));
    send_item(query_item(16'sd0, -16'sd1, 16'sd200, -16'sd1));
    // projection at start, behind start, at end, past end
    send_item(query_item(16'sd100, 16'sd10, 16'sd300, 16'sd10));
    send_item(query_item(16'sd110, 16'sd10, 16'sd300, 16'sd10));
    send_item(query_item(-16'sd100, 16'sd10, 16'sd100, 16'sd10));
    send_item(query_item(-16'sd100, 16'sd10, 16'sd99, 16'sd10));
    // corners and full-range segments
    send_item(load_item(5'd1, COORD_MIN, COORD_MIN, 10'd1023, VIS_SHOWN_ALT));
    send_item(query_item(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN));
    send_item(query_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
    send_item(load_item(5'd2, COORD_MAX, COORD_MAX, 10'd1023, VIS_SHOWN));
    send_item(query_item(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_item(query_item(COORD_MAX, COORD_MAX - 16'sd1023, COORD_MAX - 16'sd2000,
                         COORD_MAX - 16'sd1023));
    send_item(load_item(5'd31, 16'sd100, 16'sd10, 10'd10, VIS_HIDDEN));
    send_item(query_item(16'sd0, 16'sd0, 16'sd200, 16'sd0));
    // unit-length segment inside a big obstacle
    send_item(load_item(5'd0, 16'sd0, 16'sd0, 10'd1023, VIS_SHOWN_ALT));
    send_item(query_item(16'sd0, 16'sd0, 16'sd1, 16'sd0));
  endtask

  // receiver holds off while queries keep coming back to back
  task automatic test_output_stall();
    disc_t d;
    int    reach;
    d.x = rand_coord();
    d.y = rand_coord();
    d.r = 10'($urandom_range(100, 1023));
    send_item(load_item(5'd7, d.x, d.y, d.r, VIS_SHOWN));
    src_burst = 1'b1;
    hold_go   = 1'b1;
    reach     = int'(d.r) * 3;
    repeat (24) begin
      send_item(query_item(coord_near(d.x, reach), coord_near(d.y, reach),
                           coord_near(d.x, reach), coord_near(d.y, reach)));
    end
    src_burst = 1'b0;
  endtask

  // clusters of obstacles, then queries aimed at them
  task automatic test_random_scenes();
    disc_t              discs[$];
    disc_t              d;
    int                 base_x, base_y, spread, reach, n;
    logic signed [15:0] sx, sy, ex, ey;
    while (items_sent < ITEM_TARGET) begin
      src_burst = ($urandom_range(0, 3) == 0);
      base_x    = int'(rand_coord());
      base_y    = int'(rand_coord());
      case ($urandom_range(0, 2))
        0:       spread = 64;
        1:       spread = 1024;
        default: spread = 8000;
      endcase
      discs.delete();
      n = $urandom_range(1, 6);
      repeat (n) begin
        d.x = coord_near(base_x, spread);
        d.y = coord_near(base_y, spread);
        case ($urandom_range(0, 7))
          0:       d.r = 10'd0;
          1:       d.r = 10'd1023;
          2:       d.r = 10'($urandom_range(0, 31));
          default: d.r = 10'($urandom_range(0, 1023));
        endcase
        send_item(load_item(5'($urandom), d.x, d.y, d.r, 2'($urandom)));
        discs.push_back(d);
      end
      n = $urandom_range(1, 10);
      repeat (n) begin
        d     = discs[$urandom_range(0, discs.size() - 1)];
        reach = int'(d.r) * 3 + 16;
        case ($urandom_range(0, 9))
          0: begin
            sx = rand_coord();
            sy = rand_coord();
            ex = rand_coord();
            ey = rand_coord();
          end
          1: begin
            sx = coord_near(d.x, reach);
            sy = coord_near(d.y, reach);
            ex = sx;
            ey = sy;
          end
          2, 3, 4, 5: begin
            // crosses near the centre from one side to the other
            sx = coord_near(d.x, 4 * reach);
            sy = coord_near(d.y, 4 * reach);
            ex = coord_near(2 * int'(d.x) - int'(sx), reach / 2);
            ey = coord_near(2 * int'(d.y) - int'(sy), reach / 2);
          end
          default: begin
            sx = coord_near(d.x, reach);
            sy = coord_near(d.y, reach);
            ex = coord_near(d.x, reach);
            ey = coord_near(d.y, reach);
          end
        endcase
        send_item(query_item(sx, sy, ex, ey));
      end
    end
    src_burst = 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_random_scenes();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/soc_pkg.sv
rtl/segment_obstacle_collision.sv
bench/segment_obstacle_collision_tb.sv
